// ===== rtl/core/atrx_pkg.sv =====
// Shared types and character codes for the response integer field extractor.
// No dependencies; compile first.
package atrx_pkg;

	localparam int unsigned MAX_FIELD_INDEX_DEF = 15;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned VAL_W  = 32;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [VAL_W-1:0]  mag_t;

	localparam char_t CH_NUL   = 8'd0;
	localparam char_t CH_TAB   = 8'd9;
	localparam char_t CH_CR    = 8'd13;
	localparam char_t CH_SPACE = 8'd32;
	localparam char_t CH_PLUS  = 8'd43;
	localparam char_t CH_COMMA = 8'd44;
	localparam char_t CH_MINUS = 8'd45;
	localparam char_t CH_ZERO  = 8'd48;
	localparam char_t CH_NINE  = 8'd57;
	localparam char_t CH_COLON = 8'd58;

	localparam mag_t MAG_LIMIT = 32'h8000_0000;
	localparam mag_t POS_MAX   = 32'h7FFF_FFFF;

	typedef struct packed {
		char_t char_code;
		logic  last_char;
	} in_req_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] value;
	} out_req_t;

	typedef struct packed {
		idx_t field_index;
	} cfg_req_t;

endpackage

// ===== rtl/core/atrx_stream_if.sv =====
// Valid/ready channel carrying one request of a given payload type.
// Depends on nothing; payload types come from atrx_pkg at the instance.
interface atrx_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/atrx_parse.sv =====
// Per-line parse state and the single-pass step for one character.
// Depends on atrx_pkg.
module atrx_parse #(
	parameter int unsigned MAX_FIELD_INDEX = atrx_pkg::MAX_FIELD_INDEX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  atrx_pkg::in_req_t  req,
	input  atrx_pkg::idx_t     field_index,
	output atrx_pkg::out_req_t res
);
	import atrx_pkg::*;

	typedef enum logic [2:0] {
		PH_COLON,
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t ph_q, ph_n;
	idx_t   cnt_q, cnt_n;
	mag_t   acc_q, acc_n;
	logic   neg_q, neg_n;
	logic   sat_q, sat_n;
	logic   ofound_q, ofound_n;
	mag_t   oval_q, oval_n;

	char_t       c;
	logic        is_digit;
	logic        is_space;
	logic [3:0]  digit;
	logic [35:0] acc_wide;
	logic [35:0] sum;
	mag_t        acc_add;
	logic        sat_add;
	logic        selected;

	function automatic mag_t signed_value(mag_t mag, logic neg);
		if (neg) begin
			return mag_t'(~mag + 32'd1);
		end
		if (mag[31]) begin
			return POS_MAX;
		end
		return mag;
	endfunction

	assign c        = req.char_code;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign digit    = c[3:0];
	assign acc_wide = {4'b0, acc_q};
	assign sum      = (acc_wide << 3) + (acc_wide << 1) + {32'b0, digit};
	assign sat_add  = sat_q || (sum >= {4'b0, MAG_LIMIT});
	assign acc_add  = sat_q ? acc_q : ((sum >= {4'b0, MAG_LIMIT}) ? MAG_LIMIT : sum[31:0]);
	assign selected = (32'(field_index) <= 32'(MAX_FIELD_INDEX)) && (cnt_q == field_index);

	always_comb begin
		ph_n     = ph_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		sat_n    = sat_q;
		ofound_n = ofound_q;
		oval_n   = oval_q;
		case (ph_q)
			PH_COLON: begin
				if (c == CH_NUL) begin
					ofound_n = 1'b0;
					oval_n   = '0;
					ph_n     = PH_DONE;
				end else if (c == CH_COLON) begin
					ph_n = PH_LEAD;
				end
			end
			PH_LEAD: begin
				if (is_space) begin
					ph_n = PH_LEAD;
				end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
					neg_n = (c == CH_MINUS);
					ph_n  = PH_SIGN;
				end else if (is_digit) begin
					acc_n = acc_add;
					sat_n = sat_add;
					ph_n  = PH_DIGITS;
				end else begin
					ofound_n = 1'b0;
					oval_n   = '0;
					ph_n     = PH_DONE;
				end
			end
			PH_SIGN: begin
				if (is_digit) begin
					acc_n = acc_add;
					sat_n = sat_add;
					ph_n  = PH_DIGITS;
				end else begin
					ofound_n = 1'b0;
					oval_n   = '0;
					ph_n     = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					acc_n = acc_add;
					sat_n = sat_add;
				end else if (selected) begin
					ofound_n = 1'b1;
					oval_n   = signed_value(acc_q, neg_q);
					ph_n     = PH_DONE;
				end else begin
					cnt_n = cnt_q + idx_t'(1);
					acc_n = '0;
					neg_n = 1'b0;
					sat_n = 1'b0;
					if (c == CH_NUL) begin
						ofound_n = 1'b0;
						oval_n   = '0;
						ph_n     = PH_DONE;
					end else if (c == CH_COMMA) begin
						ph_n = PH_LEAD;
					end else begin
						ph_n = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (c == CH_NUL) begin
					ofound_n = 1'b0;
					oval_n   = '0;
					ph_n     = PH_DONE;
				end else if (c == CH_COMMA) begin
					ph_n = PH_LEAD;
				end
			end
			PH_DONE: begin
				ph_n = PH_DONE;
			end
			default: begin
				ph_n = ph_q;
			end
		endcase

		// close a digit run still open at the end of the line
		if (req.last_char && (ph_n == PH_DIGITS)) begin
			if (selected) begin
				ofound_n = 1'b1;
				oval_n   = signed_value(acc_n, neg_n);
			end else begin
				ofound_n = 1'b0;
				oval_n   = '0;
			end
			ph_n = PH_DONE;
		end

		res.found = (ph_n == PH_DONE) && ofound_n;
		res.value = res.found ? oval_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_COLON;
			cnt_q    <= '0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			sat_q    <= 1'b0;
			ofound_q <= 1'b0;
			oval_q   <= '0;
		end else if (step) begin
			if (req.last_char) begin
				ph_q     <= PH_COLON;
				cnt_q    <= '0;
				acc_q    <= '0;
				neg_q    <= 1'b0;
				sat_q    <= 1'b0;
				ofound_q <= 1'b0;
				oval_q   <= '0;
			end else begin
				ph_q     <= ph_n;
				cnt_q    <= cnt_n;
				acc_q    <= acc_n;
				neg_q    <= neg_n;
				sat_q    <= sat_n;
				ofound_q <= ofound_n;
				oval_q   <= oval_n;
			end
		end
	end

endmodule

// ===== rtl/core/at_response_int_field_extractor_unit.sv =====
// Top level of the response integer field extractor: input stage, result register.
// Depends on atrx_pkg, atrx_stream_if and atrx_parse.
//
//   channel  dir   payload                     accepted when
//   chars    in    char_code[7:0], last_char   valid && ready
//   result   out   found, value[31:0] signed   valid && ready
//   cfg      in    field_index[3:0]            valid && ready (ready always high)
//
// One character per cycle while no last character waits on a held result. A request is
// registered in the input stage, where the parse step (multiply by ten and add, then
// sign/saturate) runs; a line's result is registered as its last character leaves that stage.
// Reset clears the line state, the stage valids and field_index.
// Only a last character waits on a held result; other characters always advance.
module at_response_int_field_extractor_unit #(
	parameter int unsigned MAX_FIELD_INDEX = atrx_pkg::MAX_FIELD_INDEX_DEF
) (
	input logic         clk,
	input logic         arst_n,
	atrx_stream_if.sink   chars,
	atrx_stream_if.source result,
	atrx_stream_if.sink   cfg
);
	import atrx_pkg::*;

	logic     v_s1;
	in_req_t  req_s1;
	logic     adv;
	idx_t     field_index_q;
	logic     out_v_q;
	out_req_t out_q;
	out_req_t res;

	assign adv         = v_s1 && (!req_s1.last_char || !out_v_q || result.ready);
	assign chars.ready = !v_s1 || adv;
	assign cfg.ready   = 1'b1;
	assign result.valid = out_v_q;
	assign result.data  = out_q;

	atrx_parse #(
		.MAX_FIELD_INDEX (MAX_FIELD_INDEX)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.req         (req_s1),
		.field_index (field_index_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			out_v_q       <= 1'b0;
			field_index_q <= '0;
		end else begin
			if (chars.ready) begin
				v_s1 <= chars.valid;
			end
			if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
			if (adv && req_s1.last_char) begin
				out_v_q <= 1'b1;
			end
			if (cfg.valid) begin
				field_index_q <= cfg.data.field_index;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			req_s1 <= chars.data;
		end
		if (adv && req_s1.last_char) begin
			out_q <= res;
		end
	end

endmodule

// ===== rtl/core/atrx_check.sv =====
// Port-level checks on the extractor, bound to the top level.
// Depends on at_response_int_field_extractor_unit and atrx_stream_if.
module atrx_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_found,
	input logic signed [31:0] res_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_found) && $stable(res_value))
		else $error("result payload changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> res_value == 32'sd0)
		else $error("failed result carries a nonzero value");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

endmodule

bind at_response_int_field_extractor_unit atrx_check u_atrx_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (chars.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_found (result.data.found),
	.res_value (result.data.value)
);
